FILE: design/ton_pkg.sv
// ----------------------------------------------------------------------------
// ton_pkg
// Shared constants, codes and types of the telnet option negotiator.
// ----------------------------------------------------------------------------
package ton_pkg;

	localparam int CAPTURE_DEPTH_DEF = 64;

	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;
	localparam logic [7:0] OPT_TTYPE = 8'd24;
	localparam logic [7:0] OPT_NAWS  = 8'd31;

	localparam logic [2:0] OS_NONE = 3'd0;
	localparam logic [2:0] OS_WILL = 3'd1;
	localparam logic [2:0] OS_WONT = 3'd2;
	localparam logic [2:0] OS_DO   = 3'd3;
	localparam logic [2:0] OS_DONT = 3'd4;

	localparam logic [2:0] K_APP    = 3'd0;
	localparam logic [2:0] K_PEER   = 3'd1;
	localparam logic [2:0] K_WS     = 3'd2;
	localparam logic [2:0] K_TT     = 3'd3;
	localparam logic [2:0] K_TTDEF  = 3'd4;
	localparam logic [2:0] K_OSTATE = 3'd5;

	localparam logic [1:0] CMD_NET   = 2'd0;
	localparam logic [1:0] CMD_SEND  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic       rd_en;
		logic [7:0] rd_addr;
		logic       wr_en;
		logic [7:0] wr_addr;
		logic [2:0] wr_data;
	} ton_tbl_req_t;

	// Terminal-type request sent to the peer: IAC SB 24 1 IAC SE.
	function automatic logic [7:0] ttreq_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = B_IAC;
			3'd1: b = B_SB;
			3'd2: b = OPT_TTYPE;
			3'd3: b = 8'd1;
			3'd4: b = B_IAC;
			3'd5: b = B_SE;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

FILE: design/ton_opt_table.sv
// ----------------------------------------------------------------------------
// ton_opt_table
// 256-entry option state memory with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module ton_opt_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ton_pkg::ton_tbl_req_t req,
	output logic [2:0]            rd_data
);

	logic [2:0]   mem [256];
	logic [255:0] valid_q;
	logic [2:0]   rd_data_q;
	logic         rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : ton_pkg::OS_NONE;

endmodule

FILE: design/ton_cap_buf.sv
// ----------------------------------------------------------------------------
// ton_cap_buf
// Subnegotiation capture buffer with registered read; unwritten entries read 0.
// ----------------------------------------------------------------------------
module ton_cap_buf #(
	parameter int DEPTH = ton_pkg::CAPTURE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : 8'd0;

endmodule

FILE: design/telnet_option_negotiator.sv
// ----------------------------------------------------------------------------
// telnet_option_negotiator
// Telnet IAC parser with option table, subnegotiation capture and replies.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: command; tdata: data_byte, verb
// m_*      out  tuser: kind; tdata: out_byte, columns, rows, option_state;
//               tlast: last
// APB      in   reg 0 default_columns at 0x0, reg 1 default_rows at 0x4
//
// An item is accepted in S_IDLE, which starts the option table read, and is
// handled in S_EXEC; a silent item, or one result into a free output register,
// is done there. A reply burst loads one byte a cycle while the output is free:
// a three-byte reply or the terminal type request. A window size report adds four
// capture buffer reads, a merge step and a load; each terminal type byte is
// read in S_TT_RD and loaded in S_TT_CHK. Reset clears the state, parse, count
// and output valid registers and both memories' valid bits at once. A stalled
// output holds the sequencer where it stands; s_tready is high only in S_IDLE.
// ----------------------------------------------------------------------------
module telnet_option_negotiator #(
	parameter int CAPTURE_DEPTH = ton_pkg::CAPTURE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // data_byte[7:0], verb[9:8], zero
	input  logic [1:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // out_byte, columns, rows, option_state, zero
	output logic [2:0]  m_tuser,  // kind
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(CAPTURE_DEPTH);
	localparam int CW = $clog2(CAPTURE_DEPTH + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_EMIT   = 3'd2;
	localparam logic [2:0] S_TT_RD  = 3'd3;
	localparam logic [2:0] S_TT_CHK = 3'd4;
	localparam logic [2:0] S_WS     = 3'd5;

	localparam logic [3:0] P_IDLE   = 4'd0;
	localparam logic [3:0] P_IAC    = 4'd1;
	localparam logic [3:0] P_DO     = 4'd2;
	localparam logic [3:0] P_DONT   = 4'd3;
	localparam logic [3:0] P_WILL   = 4'd4;
	localparam logic [3:0] P_WONT   = 4'd5;
	localparam logic [3:0] P_SB     = 4'd6;
	localparam logic [3:0] P_SKIP   = 4'd7;
	localparam logic [3:0] P_CAP_TT = 4'd8;
	localparam logic [3:0] P_CAP_WS = 4'd9;
	localparam logic [3:0] P_CAP_OT = 4'd10;
	localparam logic [3:0] P_ESC_TT = 4'd11;
	localparam logic [3:0] P_ESC_WS = 4'd12;
	localparam logic [3:0] P_ESC_OT = 4'd13;

	localparam logic [1:0] SQ_ONE   = 2'd0;
	localparam logic [1:0] SQ_PEER3 = 2'd1;
	localparam logic [1:0] SQ_TTREQ = 2'd2;

	logic [2:0]  state_q, state_d;
	logic [3:0]  parse_q, parse_d;
	logic [1:0]  cmd_q;
	logic [7:0]  ch_q;
	logic [1:0]  verb_q;
	logic [1:0]  seq_q, seq_d;
	logic [2:0]  idx_q, idx_d;
	logic [2:0]  res_kind_q, res_kind_d;
	logic [7:0]  res_byte_q, res_byte_d;
	logic [15:0] res_cols_q, res_cols_d;
	logic [15:0] res_rows_q, res_rows_d;
	logic [2:0]  res_os_q, res_os_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] tt_i_q, tt_i_d;
	logic [2:0]  ws_i_q, ws_i_d;
	logic [23:0] acc_q, acc_d;
	logic [15:0] def_cols_q, def_rows_q;

	logic        out_valid_q;
	logic [2:0]  out_kind_q;
	logic [7:0]  out_byte_q;
	logic [15:0] out_cols_q, out_rows_q;
	logic [2:0]  out_os_q;
	logic        out_last_q;

	logic        ld_en, ld_last;
	logic [2:0]  ld_kind, ld_os;
	logic [7:0]  ld_byte;
	logic [15:0] ld_cols, ld_rows;

	ton_pkg::ton_tbl_req_t tbl_req;
	logic [2:0]  tbl_rd;
	logic        cap_wr_en, cap_rd_en;
	logic [AW-1:0] cap_wr_addr, cap_rd_addr;
	logic [7:0]  cap_wr_data, cap_rd;

	logic        accept, can_load, one_res, ww, dd, cfg_wr;

	ton_opt_table u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_data (tbl_rd)
	);

	ton_cap_buf #(
		.DEPTH (CAPTURE_DEPTH),
		.AW    (AW)
	) u_cap (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cap_wr_en),
		.wr_addr (cap_wr_addr),
		.wr_data (cap_wr_data),
		.rd_en   (cap_rd_en),
		.rd_addr (cap_rd_addr),
		.rd_data (cap_rd)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign can_load = !out_valid_q || m_tready;
	assign ww = (tbl_rd == ton_pkg::OS_WILL) || (tbl_rd == ton_pkg::OS_WONT);
	assign dd = (tbl_rd == ton_pkg::OS_DO) || (tbl_rd == ton_pkg::OS_DONT);

	always_comb begin
		state_d    = state_q;
		parse_d    = parse_q;
		seq_d      = seq_q;
		idx_d      = idx_q;
		res_kind_d = res_kind_q;
		res_byte_d = res_byte_q;
		res_cols_d = res_cols_q;
		res_rows_d = res_rows_q;
		res_os_d   = res_os_q;
		cnt_d      = cnt_q;
		tt_i_d     = tt_i_q;
		ws_i_d     = ws_i_q;
		acc_d      = acc_q;
		one_res    = 1'b0;
		ld_en      = 1'b0;
		ld_kind    = ton_pkg::K_APP;
		ld_byte    = 8'd0;
		ld_cols    = 16'd0;
		ld_rows    = 16'd0;
		ld_os      = ton_pkg::OS_NONE;
		ld_last    = 1'b0;
		tbl_req    = '0;
		cap_wr_en   = 1'b0;
		cap_wr_addr = cnt_q[AW-1:0];
		cap_wr_data = ch_q;
		cap_rd_en   = 1'b0;
		cap_rd_addr = tt_i_q[AW-1:0];

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					tbl_req.rd_en   = 1'b1;
					tbl_req.rd_addr = s_tdata[7:0];
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d         = S_IDLE;
				tbl_req.wr_addr = ch_q;
				res_kind_d = ton_pkg::K_APP;
				res_byte_d = 8'd0;
				res_cols_d = 16'd0;
				res_rows_d = 16'd0;
				res_os_d   = ton_pkg::OS_NONE;
				idx_d      = 3'd0;
				case (cmd_q)
					ton_pkg::CMD_SEND: begin
						tbl_req.wr_en   = 1'b1;
						tbl_req.wr_data = ton_pkg::OS_WILL + {1'b0, verb_q};
						res_byte_d = ton_pkg::B_WILL + {6'd0, verb_q};
						seq_d   = SQ_PEER3;
						state_d = S_EMIT;
					end
					ton_pkg::CMD_QUERY: begin
						res_kind_d = ton_pkg::K_OSTATE;
						res_os_d   = tbl_rd;
						one_res    = 1'b1;
					end
					ton_pkg::CMD_NET: begin
						case (parse_q)
							P_IDLE: begin
								if (ch_q == ton_pkg::B_IAC) begin
									parse_d = P_IAC;
								end else begin
									res_byte_d = ch_q;
									one_res    = 1'b1;
								end
							end
							P_IAC: begin
								case (ch_q)
									ton_pkg::B_IAC: begin
										parse_d    = P_IDLE;
										res_byte_d = ch_q;
										one_res    = 1'b1;
									end
									ton_pkg::B_DO:   parse_d = P_DO;
									ton_pkg::B_DONT: parse_d = P_DONT;
									ton_pkg::B_WILL: parse_d = P_WILL;
									ton_pkg::B_WONT: parse_d = P_WONT;
									ton_pkg::B_SB:   parse_d = P_SB;
									default:         parse_d = P_SKIP;
								endcase
							end
							P_DO, P_DONT: begin
								parse_d       = P_IDLE;
								tbl_req.wr_en = 1'b1;
								if (ww) begin
									tbl_req.wr_data = (parse_q == P_DO) ?
										ton_pkg::OS_DO : ton_pkg::OS_DONT;
								end else begin
									tbl_req.wr_data = ton_pkg::OS_WONT;
									res_byte_d = ton_pkg::B_WONT;
									seq_d   = SQ_PEER3;
									state_d = S_EMIT;
								end
							end
							P_WILL: begin
								parse_d       = P_IDLE;
								tbl_req.wr_en = 1'b1;
								if (dd) begin
									tbl_req.wr_data = ton_pkg::OS_WILL;
									if (ch_q == ton_pkg::OPT_TTYPE) begin
										seq_d   = SQ_TTREQ;
										state_d = S_EMIT;
									end
								end else begin
									tbl_req.wr_data = ton_pkg::OS_DONT;
									res_byte_d = ton_pkg::B_DONT;
									seq_d   = SQ_PEER3;
									state_d = S_EMIT;
								end
							end
							P_WONT: begin
								parse_d       = P_IDLE;
								tbl_req.wr_en = 1'b1;
								if (dd) begin
									tbl_req.wr_data = ton_pkg::OS_WONT;
									if (ch_q == ton_pkg::OPT_TTYPE) begin
										res_kind_d = ton_pkg::K_TTDEF;
										one_res    = 1'b1;
									end else if (ch_q == ton_pkg::OPT_NAWS) begin
										res_kind_d = ton_pkg::K_WS;
										res_cols_d = def_cols_q;
										res_rows_d = def_rows_q;
										one_res    = 1'b1;
									end
								end else begin
									tbl_req.wr_data = ton_pkg::OS_DONT;
									res_byte_d = ton_pkg::B_DONT;
									seq_d   = SQ_PEER3;
									state_d = S_EMIT;
								end
							end
							P_SB: begin
								cnt_d = '0;
								if (ch_q == ton_pkg::OPT_TTYPE) begin
									parse_d = P_CAP_TT;
								end else if (ch_q == ton_pkg::OPT_NAWS) begin
									parse_d = P_CAP_WS;
								end else begin
									parse_d = P_CAP_OT;
								end
							end
							P_CAP_TT, P_CAP_WS, P_CAP_OT,
							P_ESC_TT, P_ESC_WS, P_ESC_OT: begin
								if (parse_q == P_CAP_TT || parse_q == P_CAP_WS ||
								    parse_q == P_CAP_OT) begin
									if (ch_q == ton_pkg::B_IAC) begin
										parse_d = parse_q + 4'd3;
									end
								end else if (ch_q == ton_pkg::B_IAC) begin
									parse_d = parse_q - 4'd3;
								end else begin
									parse_d = P_IDLE;
									if (ch_q == ton_pkg::B_SE && parse_q == P_ESC_TT) begin
										tt_i_d  = CW'(1);
										state_d = S_TT_RD;
									end else if (ch_q == ton_pkg::B_SE &&
									             parse_q == P_ESC_WS) begin
										ws_i_d  = 3'd0;
										state_d = S_WS;
									end
								end
								if ((ch_q != ton_pkg::B_IAC) == (parse_q < P_ESC_TT) &&
								    cnt_q < CW'(CAPTURE_DEPTH)) begin
									cap_wr_en = 1'b1;
									cnt_d     = cnt_q + CW'(1);
								end
							end
							default: begin
								parse_d = P_IDLE;
							end
						endcase
					end
					default: begin
					end
				endcase
				if (one_res) begin
					if (can_load) begin
						ld_en   = 1'b1;
						ld_kind = res_kind_d;
						ld_byte = res_byte_d;
						ld_cols = res_cols_d;
						ld_rows = res_rows_d;
						ld_os   = res_os_d;
						ld_last = 1'b1;
					end else begin
						seq_d   = SQ_ONE;
						state_d = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (can_load) begin
					ld_en = 1'b1;
					case (seq_q)
						SQ_ONE: begin
							ld_kind = res_kind_q;
							ld_byte = res_byte_q;
							ld_cols = res_cols_q;
							ld_rows = res_rows_q;
							ld_os   = res_os_q;
							ld_last = 1'b1;
						end
						SQ_PEER3: begin
							ld_kind = ton_pkg::K_PEER;
							case (idx_q)
								3'd0:    ld_byte = ton_pkg::B_IAC;
								3'd1:    ld_byte = res_byte_q;
								default: ld_byte = ch_q;
							endcase
							ld_last = (idx_q == 3'd2);
						end
						default: begin
							ld_kind = ton_pkg::K_PEER;
							ld_byte = ton_pkg::ttreq_byte(idx_q);
							ld_last = (idx_q == 3'd5);
						end
					endcase
					idx_d = idx_q + 3'd1;
					if (ld_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_TT_RD: begin
				if (tt_i_q < cnt_q) begin
					cap_rd_en = 1'b1;
					state_d   = S_TT_CHK;
				end else if (can_load) begin
					ld_en   = 1'b1;
					ld_kind = ton_pkg::K_TT;
					ld_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_TT_CHK: begin
				if (can_load) begin
					ld_en   = 1'b1;
					ld_kind = ton_pkg::K_TT;
					ld_byte = cap_rd;
					if (cap_rd == 8'd0) begin
						ld_last = 1'b1;
						state_d = S_IDLE;
					end else begin
						tt_i_d  = tt_i_q + CW'(1);
						state_d = S_TT_RD;
					end
				end
			end
			S_WS: begin
				if (ws_i_q != 3'd0) begin
					acc_d = {acc_q[15:0], cap_rd};
				end
				if (ws_i_q < 3'd4) begin
					cap_rd_en   = 1'b1;
					cap_rd_addr = AW'(ws_i_q);
					ws_i_d      = ws_i_q + 3'd1;
				end else begin
					res_kind_d = ton_pkg::K_WS;
					res_byte_d = 8'd0;
					res_cols_d = acc_q[23:8];
					res_rows_d = {acc_q[7:0], cap_rd};
					res_os_d   = ton_pkg::OS_NONE;
					seq_d      = SQ_ONE;
					state_d    = S_EMIT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			parse_q     <= P_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			def_cols_q  <= 16'd80;
			def_rows_q  <= 16'd25;
		end else begin
			state_q <= state_d;
			parse_q <= parse_d;
			cnt_q   <= cnt_d;
			if (ld_en) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				if (paddr[2]) begin
					def_rows_q <= pwdata[15:0];
				end else begin
					def_cols_q <= pwdata[15:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tuser;
			ch_q   <= s_tdata[7:0];
			verb_q <= s_tdata[9:8];
		end
		seq_q      <= seq_d;
		idx_q      <= idx_d;
		res_kind_q <= res_kind_d;
		res_byte_q <= res_byte_d;
		res_cols_q <= res_cols_d;
		res_rows_q <= res_rows_d;
		res_os_q   <= res_os_d;
		tt_i_q     <= tt_i_d;
		ws_i_q     <= ws_i_d;
		acc_q      <= acc_d;
		if (ld_en) begin
			out_kind_q <= ld_kind;
			out_byte_q <= ld_byte;
			out_cols_q <= ld_cols;
			out_rows_q <= ld_rows;
			out_os_q   <= ld_os;
			out_last_q <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {5'd0, out_os_q, out_rows_q, out_cols_q, out_byte_q};
	assign m_tlast  = out_last_q;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = {16'd0, paddr[2] ? def_rows_q : def_cols_q};

endmodule
